// ===== rtl/core/process_slot_table_core_macros.svh =====
// ----------------------------------------------------------------------------
// process_slot_table_core_macros.svh
// Assertion macros for the process slot table core.
// ----------------------------------------------------------------------------
`ifndef PROCESS_SLOT_TABLE_CORE_MACROS_SVH
`define PROCESS_SLOT_TABLE_CORE_MACROS_SVH

`ifndef SYNTHESIS

// check that cons holds in the same cycle as ante
`define PST_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("process slot table assertion failed");

// check that cons holds in the cycle after ante
`define PST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("process slot table assertion failed");

`else

`define PST_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PST_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/pst_pkg.sv =====
// ----------------------------------------------------------------------------
// pst_pkg
// Types and constants shared by the process slot table core and its cells.
// ----------------------------------------------------------------------------
package pst_pkg;

    localparam int SLOTS  = 64;
    localparam int ID_W   = 31;
    localparam int ROOT_W = 52;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int LIVE_W = 7;
    localparam int MEM_W  = 17;

    localparam logic [ID_W-1:0]  ID_MAX        = {ID_W{1'b1}};
    localparam logic [ID_W-1:0]  ID_FIRST      = ID_W'(1);
    localparam logic [MEM_W-1:0] MEM_BYTES     = MEM_W'(65536);
    localparam logic             FOUND_THREADS = 1'b1;

    typedef enum logic [1:0] {
        ACT_SPAWN = 2'd0,
        ACT_KILL  = 2'd1,
        ACT_FIND  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_ZERO_ID   = 2'd3
    } status_t;

    // request beat walking down the cell chain
    typedef struct packed {
        logic              done;
        action_t           action;
        logic [ID_W-1:0]   pid;
        logic [ROOT_W-1:0] root;
        status_t           status;
    } cell_tok_t;

endpackage

// ===== rtl/core/pst_cell.sv =====
// ----------------------------------------------------------------------------
// pst_cell
// One process slot: holds live flag, id and page root, acts on the passing
// request beat, registers it and hands it to the next cell in the cycle after.
// ----------------------------------------------------------------------------
module pst_cell
    import pst_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      tok_valid_in,
    input  cell_tok_t tok_in,
    output logic      tok_valid_out,
    output cell_tok_t tok_out
);

    logic              live_reg;
    logic              live_next;
    logic [ID_W-1:0]   id_reg;
    logic [ROOT_W-1:0] root_reg;
    logic              tok_valid_reg;
    cell_tok_t         tok_reg;
    cell_tok_t         tok_next;
    logic              claim;
    logic              match;

    // decide whether this slot serves the beat
    always_comb
    begin
        claim = tok_valid_in && !tok_in.done && (tok_in.action == ACT_SPAWN) && !live_reg;
        match = tok_valid_in && !tok_in.done && live_reg && (id_reg == tok_in.pid)
                && ((tok_in.action == ACT_KILL) || (tok_in.action == ACT_FIND));

        tok_next  = tok_in;
        live_next = live_reg;
        if (claim)
        begin
            tok_next.done   = 1'b1;
            tok_next.status = ST_OK;
            live_next       = 1'b1;
        end
        else if (match)
        begin
            tok_next.done   = 1'b1;
            tok_next.status = ST_OK;
            if (tok_in.action == ACT_FIND)
            begin
                tok_next.root = root_reg;
            end
            else
            begin
                live_next = 1'b0;
            end
        end
    end

    // hold slot occupancy and beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg      <= 1'b0;
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            live_reg      <= live_next;
            tok_valid_reg <= tok_valid_in;
        end
    end

    // store slot payload on spawn, advance beat payload
    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
        if (claim)
        begin
            id_reg   <= tok_in.pid;
            root_reg <= tok_in.root;
        end
    end

    assign tok_valid_out = tok_valid_reg;
    assign tok_out       = tok_reg;

endmodule

// ===== rtl/core/process_slot_table_core.sv =====
// The request beat walks the slot cells one per cycle; done and the result are
// registered from the beat as it leaves the last cell.
// A new action is taken only while not busy; busy drops in the done cycle.
// Reset: all slots free, id counter at 1, live count 0.
// Each result is shown for one cycle under done; the receiver cannot stall.
// ----------------------------------------------------------------------------
// process_slot_table_core
// Process slot table: spawn, kill and find actions over a chain of slot cells.
// ----------------------------------------------------------------------------
`include "process_slot_table_core_macros.svh"

module process_slot_table_core
    import pst_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        action,
    input  logic [ID_W-1:0]   pid,
    input  logic [ROOT_W-1:0] page_root,
    output logic              done,
    output logic [1:0]        status,
    output logic [ID_W-1:0]   result_pid,
    output logic [ROOT_W-1:0] found_root,
    output logic              threads,
    output logic [MEM_W-1:0]  memory_bytes,
    output logic [LIVE_W-1:0] live_count
);

    logic              accept;
    action_t           act;
    logic [SLOTS:0]    tok_valid;
    cell_tok_t         tok [SLOTS+1];
    cell_tok_t         entry_tok;
    cell_tok_t         last;
    logic              last_ok;

    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic [ID_W-1:0]   id_ctr_reg;
    logic [ID_W-1:0]   id_ctr_next;
    logic [CNT_W-1:0]  active_total_reg;
    logic [CNT_W-1:0]  active_total_next;
    status_t           status_reg;
    logic [ID_W-1:0]   result_pid_reg;
    logic [ROOT_W-1:0] found_root_reg;
    logic              found_reg;

    assign accept = start && !busy_reg;
    assign act    = action_t'(action);

    // form the entry beat; zero id and unused code are marked done at entry
    always_comb
    begin
        entry_tok.done   = 1'b0;
        entry_tok.action = act;
        entry_tok.pid    = pid;
        entry_tok.root   = page_root;
        entry_tok.status = ST_NOT_FOUND;
        unique case (act) inside
            ACT_SPAWN:
            begin
                entry_tok.pid    = id_ctr_reg;
                entry_tok.status = ST_FULL;
            end
            ACT_KILL, ACT_FIND:
            begin
                if (pid == '0)
                begin
                    entry_tok.done   = 1'b1;
                    entry_tok.status = ST_ZERO_ID;
                end
            end
            default:
            begin
                entry_tok.done = 1'b1;
            end
        endcase
    end

    assign tok_valid[0] = accept;
    assign tok[0]       = entry_tok;

    // chain of slot cells
    for (genvar g = 0; g < SLOTS; g++)
    begin : g_cell
        pst_cell u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .tok_valid_in  (tok_valid[g]),
            .tok_in        (tok[g]),
            .tok_valid_out (tok_valid[g+1]),
            .tok_out       (tok[g+1])
        );
    end

    assign last    = tok[SLOTS];
    assign last_ok = (last.status == ST_OK);

    // set busy on accept; update busy and counters when the beat leaves the chain
    always_comb
    begin
        busy_next         = busy_reg;
        id_ctr_next       = id_ctr_reg;
        active_total_next = active_total_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        if (tok_valid[SLOTS])
        begin
            busy_next = 1'b0;
            if (last_ok && (last.action == ACT_SPAWN))
            begin
                id_ctr_next       = (id_ctr_reg == ID_MAX) ? ID_FIRST : id_ctr_reg + ID_FIRST;
                active_total_next = active_total_reg + CNT_W'(1);
            end
            else if (last_ok && (last.action == ACT_KILL) && (active_total_reg != '0))
            begin
                active_total_next = active_total_reg - CNT_W'(1);
            end
        end
    end

    // hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b0;
            done_reg         <= 1'b0;
            id_ctr_reg       <= ID_FIRST;
            active_total_reg <= '0;
        end
        else
        begin
            busy_reg         <= busy_next;
            done_reg         <= tok_valid[SLOTS];
            id_ctr_reg       <= id_ctr_next;
            active_total_reg <= active_total_next;
        end
    end

    // register the result beat
    always_ff @(posedge clk)
    begin
        if (tok_valid[SLOTS])
        begin
            status_reg     <= last.status;
            result_pid_reg <= last_ok ? last.pid : '0;
            found_reg      <= last_ok && (last.action == ACT_FIND);
            found_root_reg <= (last_ok && (last.action == ACT_FIND)) ? last.root : '0;
        end
    end

    assign busy         = busy_reg;
    assign done         = done_reg;
    assign status       = status_reg;
    assign result_pid   = result_pid_reg;
    assign found_root   = found_root_reg;
    assign threads      = found_reg ? FOUND_THREADS : 1'b0;
    assign memory_bytes = found_reg ? MEM_BYTES : '0;
    assign live_count   = LIVE_W'(active_total_reg);

    // checks
    `PST_ASSERT_IMPL(a_one_beat, clk, rst_n, 1'b1, $onehot0(tok_valid[SLOTS:1]))
    `PST_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, accept, busy_reg)
    `PST_ASSERT_IMPL(a_done_from_busy, clk, rst_n, done_reg, $past(busy_reg))
    `PST_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, active_total_reg <= CNT_W'(SLOTS))
    `PST_ASSERT_IMPL(a_id_nonzero, clk, rst_n, 1'b1, id_ctr_reg != '0)

endmodule
